>>> src/q2e_pkg.sv
// Package for the quaternion to Euler angle converter.
// Holds fixed widths, angle constants and the CORDIC arctangent table.
// No dependencies.
package q2e_pkg;

    localparam int AW = 34;          // product / CORDIC x,y width (Q.28 plus growth)
    localparam int ZW = 28;          // angle accumulator width (2^24 per radian)
    localparam int SQW = 58;         // radicand width for the square root

    localparam logic signed [ZW-1:0] ANG_PI = 28'sd52707178;
    localparam logic signed [AW-1:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [15:0] PITCH_LIM = 16'sd12868;
    localparam logic signed [15:0] FULL_LIM = 16'sd25736;

    typedef logic signed [AW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    function automatic t_ang atan_entry(input int i);
        case (i)
            0: atan_entry = 28'sd13176795;
            1: atan_entry = 28'sd7778716;
            2: atan_entry = 28'sd4110060;
            3: atan_entry = 28'sd2086331;
            4: atan_entry = 28'sd1047214;
            5: atan_entry = 28'sd524117;
            6: atan_entry = 28'sd262123;
            7: atan_entry = 28'sd131069;
            default: begin
                if (i <= 24) atan_entry = t_ang'(28'sd1 <<< (24 - i));
                else atan_entry = '0;
            end
        endcase
    endfunction

    function automatic logic signed [15:0] to_q13(input t_ang z, input logic signed [15:0] lim);
        logic signed [ZW:0] r;
        r = ($signed({z[ZW-1], z}) + (ZW+1)'(1024)) >>> 11;
        if (r > (ZW+1)'(lim)) to_q13 = lim;
        else if (r < -(ZW+1)'(lim)) to_q13 = -lim;
        else to_q13 = r[15:0];
    endfunction

endpackage

>>> src/quaternion_to_euler_unit.sv
// Quaternion to Euler angle (ZYX) converter, fully pipelined.
// Stages in order: rescale, products, sums, square, square root, pre-rotation,
// CORDIC iterations and output register; one item per cycle. The square root (29 stages, one result bit
// each) sets the depth, then the three CORDIC pipelines run in parallel.
// busy is always low; the receiver cannot stall.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// Depends on q2e_pkg.
module quaternion_to_euler_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_quat_x,
    input  logic signed [DATA_WIDTH-1:0] i_quat_y,
    input  logic signed [DATA_WIDTH-1:0] i_quat_z,
    input  logic signed [DATA_WIDTH-1:0] i_quat_w,
    output logic                         o_valid,
    output logic signed [15:0]           o_roll_angle,
    output logic signed [14:0]           o_pitch_angle,
    output logic signed [15:0]           o_yaw_angle,
    output logic                         o_pitch_saturated
);
    localparam int AW = q2e_pkg::AW;
    localparam int ZW = q2e_pkg::ZW;
    localparam int SQW = q2e_pkg::SQW;
    localparam int SQ_STEPS = SQW / 2;   // 29 digit steps
    localparam int NC = CORDIC_STAGES;

    assign busy = 1'b0;

    // Stage 0: rescale inputs to Q1.14.
    function automatic logic signed [16:0] rescale(input logic signed [DATA_WIDTH-1:0] v);
        logic signed [DATA_WIDTH+16:0] t;
        t = (DATA_WIDTH+17)'(v);
        if (DATA_WIDTH > 16) rescale = 17'(t >>> (DATA_WIDTH - 16));
        else rescale = 17'(t <<< (16 - DATA_WIDTH));
    endfunction

    logic signed [16:0] r_x, r_y, r_z, r_w;
    logic               r_v0;
    always_ff @(posedge i_clk) begin
        r_x <= rescale(i_quat_x);
        r_y <= rescale(i_quat_y);
        r_z <= rescale(i_quat_z);
        r_w <= rescale(i_quat_w);
        if (!i_rst_n) r_v0 <= 1'b0;
        else r_v0 <= start;
    end

    // Stage 1: products, one multiplier each.
    logic signed [33:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic               r_v1;
    always_ff @(posedge i_clk) begin
        r_wx <= r_w * r_x; r_yz <= r_y * r_z; r_xx <= r_x * r_x;
        r_yy <= r_y * r_y; r_wz <= r_w * r_z; r_xy <= r_x * r_y;
        r_zz <= r_z * r_z; r_wy <= r_w * r_y; r_zx <= r_z * r_x;
        if (!i_rst_n) r_v1 <= 1'b0;
        else r_v1 <= r_v0;
    end

    // Stage 2: sums.
    logic signed [AW-1:0] r_sr, r_cr, r_sy, r_cy, r_sp;
    logic                 r_v2;
    always_ff @(posedge i_clk) begin
        r_sr <= (r_wx + r_yz) <<< 1;
        r_cr <= q2e_pkg::ONE_Q28 - ((r_xx + r_yy) <<< 1);
        r_sy <= (r_wz + r_xy) <<< 1;
        r_cy <= q2e_pkg::ONE_Q28 - ((r_yy + r_zz) <<< 1);
        r_sp <= (r_wy - r_zx) <<< 1;
        if (!i_rst_n) r_v2 <= 1'b0;
        else r_v2 <= r_v1;
    end

    // Stage 3: saturation test and square of the pitch sine.
    logic signed [AW-1:0] r_sr3, r_cr3, r_sy3, r_cy3, r_sp3;
    logic [SQW-1:0]       r_rad;
    logic                 r_sat3, r_v3;
    logic                 sat_now;
    logic [AW-1:0]        sp_abs;
    assign sat_now = (r_sp >= q2e_pkg::ONE_Q28) || (r_sp <= -q2e_pkg::ONE_Q28);
    assign sp_abs = r_sp[AW-1] ? AW'(-r_sp) : AW'(r_sp);
    always_ff @(posedge i_clk) begin
        r_sr3 <= r_sr; r_cr3 <= r_cr; r_sy3 <= r_sy; r_cy3 <= r_cy; r_sp3 <= r_sp;
        r_sat3 <= sat_now;
        // |s| < 2^28 when used, so the 29-bit square fits one multiplier.
        r_rad <= (SQW'(1) << 56) - (SQW'(sp_abs[28:0]) * SQW'(sp_abs[28:0]));
        if (!i_rst_n) r_v3 <= 1'b0;
        else r_v3 <= r_v2;
    end

    // Square root pipeline: one result bit per stage, radicand consumed two bits a stage.
    logic [SQW-1:0]       r_sq_rem [SQ_STEPS+1];
    logic [SQW-1:0]       r_sq_val [SQ_STEPS+1];
    logic [SQ_STEPS-1:0]  r_sq_res [SQ_STEPS+1];
    logic signed [AW-1:0] r_sq_sr [SQ_STEPS+1], r_sq_cr [SQ_STEPS+1];
    logic signed [AW-1:0] r_sq_sy [SQ_STEPS+1], r_sq_cy [SQ_STEPS+1], r_sq_sp [SQ_STEPS+1];
    logic                 r_sq_sat [SQ_STEPS+1];
    logic                 r_sq_v [SQ_STEPS+1];

    always_comb begin
        r_sq_rem[0] = '0; r_sq_val[0] = r_rad; r_sq_res[0] = '0;
        r_sq_sr[0] = r_sr3; r_sq_cr[0] = r_cr3; r_sq_sy[0] = r_sy3; r_sq_cy[0] = r_cy3;
        r_sq_sp[0] = r_sp3; r_sq_sat[0] = r_sat3; r_sq_v[0] = r_v3;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [SQW+1:0] rem_sh, trial;
        assign rem_sh = {r_sq_rem[k], r_sq_val[k][SQW-1 -: 2]};
        assign trial = {(SQW+2-SQ_STEPS-2)'(0), r_sq_res[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (rem_sh >= trial) begin
                r_sq_rem[k+1] <= SQW'(rem_sh - trial);
                r_sq_res[k+1] <= {r_sq_res[k][SQ_STEPS-2:0], 1'b1};
            end else begin
                r_sq_rem[k+1] <= SQW'(rem_sh);
                r_sq_res[k+1] <= {r_sq_res[k][SQ_STEPS-2:0], 1'b0};
            end
            r_sq_val[k+1] <= r_sq_val[k] << 2;
            r_sq_sr[k+1] <= r_sq_sr[k]; r_sq_cr[k+1] <= r_sq_cr[k];
            r_sq_sy[k+1] <= r_sq_sy[k]; r_sq_cy[k+1] <= r_sq_cy[k];
            r_sq_sp[k+1] <= r_sq_sp[k]; r_sq_sat[k+1] <= r_sq_sat[k];
            if (!i_rst_n) r_sq_v[k+1] <= 1'b0;
            else r_sq_v[k+1] <= r_sq_v[k];
        end
    end

    // CORDIC pre-rotation and iterations, three lanes (0 roll, 1 yaw, 2 pitch).
    logic signed [AW+1:0] r_cx [3][NC+1];
    logic signed [AW+1:0] r_cy_ [3][NC+1];
    logic signed [ZW-1:0] r_cz [3][NC+1];
    logic                 r_cd_sat [NC+1];
    logic                 r_cd_v [NC+1];

    logic signed [AW-1:0] pre_y [3], pre_x [3];
    assign pre_y[0] = r_sq_sr[SQ_STEPS]; assign pre_x[0] = r_sq_cr[SQ_STEPS];
    assign pre_y[1] = r_sq_sy[SQ_STEPS]; assign pre_x[1] = r_sq_cy[SQ_STEPS];
    assign pre_y[2] = r_sq_sp[SQ_STEPS];
    assign pre_x[2] = AW'({1'b0, r_sq_res[SQ_STEPS]});

    for (genvar l = 0; l < 3; l++) begin : g_pre
        always_ff @(posedge i_clk) begin
            // Both zero: x, y stay zero, so every stage adds +a_i; use z start that
            // cannot matter only when handled at the output by the zero flag below.
            if (pre_x[l] < 0) begin
                r_cx[l][0] <= -(AW+2)'(pre_x[l]);
                r_cy_[l][0] <= -(AW+2)'(pre_y[l]);
                r_cz[l][0] <= (pre_y[l] >= 0) ? q2e_pkg::ANG_PI : -q2e_pkg::ANG_PI;
            end else begin
                r_cx[l][0] <= (AW+2)'(pre_x[l]);
                r_cy_[l][0] <= (AW+2)'(pre_y[l]);
                r_cz[l][0] <= '0;
            end
        end
    end

    logic [2:0] r_zero [NC+1];
    always_ff @(posedge i_clk) begin
        r_cd_sat[0] <= r_sq_sat[SQ_STEPS];
        r_zero[0] <= {pre_x[2] == 0 && pre_y[2] == 0, pre_x[1] == 0 && pre_y[1] == 0,
                      pre_x[0] == 0 && pre_y[0] == 0};
        if (!i_rst_n) r_cd_v[0] <= 1'b0;
        else r_cd_v[0] <= r_sq_v[SQ_STEPS];
    end

    for (genvar i = 0; i < NC; i++) begin : g_cordic
        for (genvar l = 0; l < 3; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (r_cy_[l][i] >= 0) begin
                    r_cx[l][i+1] <= r_cx[l][i] + (r_cy_[l][i] >>> i);
                    r_cy_[l][i+1] <= r_cy_[l][i] - (r_cx[l][i] >>> i);
                    r_cz[l][i+1] <= r_cz[l][i] + q2e_pkg::atan_entry(i);
                end else begin
                    r_cx[l][i+1] <= r_cx[l][i] - (r_cy_[l][i] >>> i);
                    r_cy_[l][i+1] <= r_cy_[l][i] + (r_cx[l][i] >>> i);
                    r_cz[l][i+1] <= r_cz[l][i] - q2e_pkg::atan_entry(i);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_cd_sat[i+1] <= r_cd_sat[i];
            r_zero[i+1] <= r_zero[i];
            if (!i_rst_n) r_cd_v[i+1] <= 1'b0;
            else r_cd_v[i+1] <= r_cd_v[i];
        end
    end

    // Output stage: rounding, clamping and the pitch override.
    logic signed [15:0] pitch_full;
    always_comb begin
        if (r_cd_sat[NC]) pitch_full = r_cy_[2][NC] > 0 ? q2e_pkg::PITCH_LIM : -q2e_pkg::PITCH_LIM;
        else if (r_zero[NC][2]) pitch_full = '0;
        else pitch_full = q2e_pkg::to_q13(r_cz[2][NC], q2e_pkg::PITCH_LIM);
    end

    // Saturated pitch sign: the pipelined y of lane two starts as s itself, but the rotation
    // drives it toward zero, so its sign after rotation is not reliably s's sign; track s separately.
    logic r_sp_pos [NC+1];
    always_ff @(posedge i_clk) begin
        r_sp_pos[0] <= r_sq_sp[SQ_STEPS] > 0;
    end
    for (genvar i = 0; i < NC; i++) begin : g_sgn
        always_ff @(posedge i_clk) r_sp_pos[i+1] <= r_sp_pos[i];
    end

    always_ff @(posedge i_clk) begin
        o_roll_angle <= r_zero[NC][0] ? 16'sd0 : q2e_pkg::to_q13(r_cz[0][NC], q2e_pkg::FULL_LIM);
        o_yaw_angle <= r_zero[NC][1] ? 16'sd0 : q2e_pkg::to_q13(r_cz[1][NC], q2e_pkg::FULL_LIM);
        if (r_cd_sat[NC])
            o_pitch_angle <= r_sp_pos[NC] ? 15'(q2e_pkg::PITCH_LIM) : 15'(-q2e_pkg::PITCH_LIM);
        else
            o_pitch_angle <= pitch_full[14:0];
        o_pitch_saturated <= r_cd_sat[NC];
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r_cd_v[NC];
    end

endmodule
